>>> hdl/cmpi_pkg.sv
// Shared types, constants and helpers for the contact manifold point insert block.
`timescale 1ns / 1ps
package cmpi_pkg;
   localparam int MAX_POINTS_DEFAULT = 4;
   localparam logic [31:0] MATCH_DIST_RESET = 32'd655;
   localparam logic [15:0] NORMAL_TOL_RESET = 16'd164;

   localparam logic CSR_MATCH_DIST = 1'b0;
   localparam logic CSR_NORMAL_TOL = 1'b1;

   localparam logic [2:0] ST_APPENDED = 3'd0;
   localparam logic [2:0] ST_MATCHED  = 3'd1;
   localparam logic [2:0] ST_REJECTED = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_CLEARED  = 3'd4;

   // Controller to datapath.
   typedef struct packed {
      logic load;      // capture the request beat
      logic mul_world; // world products for one component
      logic acc_world; // sum world products into difference
      logic mul_dot;   // normal times difference
      logic acc_dot;   // accumulate dot product
      logic check_pt;  // compare one stored point
      logic commit;    // write the result registers and store
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_clear;
      logic normal_ok;
      logic hit;
   } sts_type;

   function automatic logic signed [15:0] comp(input logic [47:0] v, input logic [1:0] k);
      logic signed [15:0] r;
      case (k)
         2'd0: r = v[15:0];
         2'd1: r = v[31:16];
         default: r = v[47:32];
      endcase
      return r;
   endfunction
endpackage

>>> hdl/cmpi_datapath.sv
// Datapath: normal test, point matching, depth arithmetic and point store.
`timescale 1ns / 1ps
module cmpi_datapath #(
   parameter int MAX_POINTS = cmpi_pkg::MAX_POINTS_DEFAULT,
   parameter int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   parameter int CNT_W = $clog2(MAX_POINTS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  cmpi_pkg::cmd_type   cmd,
   input  logic [1:0]          comp_sel,
   input  logic [IDX_W-1:0]    pt_sel,
   output cmpi_pkg::sts_type   sts,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                req_op,
   input  logic [47:0]         req_local_a,
   input  logic [47:0]         req_local_b,
   input  logic [47:0]         req_contact_normal,
   input  logic [47:0]         req_a_row0,
   input  logic [47:0]         req_a_row1,
   input  logic [47:0]         req_a_row2,
   input  logic [47:0]         req_a_position,
   input  logic [47:0]         req_b_row0,
   input  logic [47:0]         req_b_row1,
   input  logic [47:0]         req_b_row2,
   input  logic [47:0]         req_b_position,
   input  logic [2:0]          commit_status,
   input  logic [IDX_W-1:0]    hit_idx,
   output logic [CNT_W-1:0]    count,
   output logic [2:0]          rsp_status,
   output logic [2:0]          rsp_slot,
   output logic signed [31:0]  rsp_depth,
   output logic [2:0]          rsp_points_held
);
   import cmpi_pkg::*;

   logic [31:0] match_ff;
   logic [15:0] tol_ff;
   logic        op_ff;
   logic [47:0] la_ff, lb_ff, n_ff;
   logic [47:0] ar_ff [3];
   logic [47:0] br_ff [3];
   logic [47:0] ap_ff, bp_ff;
   logic [47:0] store_a [MAX_POINTS];
   logic [47:0] store_b [MAX_POINTS];
   logic [47:0] store_n [MAX_POINTS];
   logic [31:0] store_d [MAX_POINTS];
   logic [CNT_W-1:0] count_ff, count_in;
   logic        nok_ff, hit_ff;
   logic signed [31:0] pa_ff [4];
   logic signed [31:0] pb_ff [4];
   logic signed [34:0] diff_ff;
   logic signed [50:0] prod_ff;
   logic signed [53:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= MATCH_DIST_RESET;
         tol_ff   <= NORMAL_TOL_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_MATCH_DIST) match_ff <= csr_wdata;
         else tol_ff <= csr_wdata[15:0];
      end
   end

   // normal length test on the request beat
   logic signed [31:0] nx2, ny2, nz2;
   logic signed [34:0] len, dev;
   logic               nok_in;
   always_comb begin
      nx2 = comp(req_contact_normal, 2'd0) * comp(req_contact_normal, 2'd0);
      ny2 = comp(req_contact_normal, 2'd1) * comp(req_contact_normal, 2'd1);
      nz2 = comp(req_contact_normal, 2'd2) * comp(req_contact_normal, 2'd2);
      len = 35'(nx2) + 35'(ny2) + 35'(nz2);
      dev = (35'sd1 <<< 28) - len;
      if (dev < 0) dev = -dev;
      nok_in = dev <= $signed({5'd0, tol_ff, 14'd0});
   end

   // squared distance of one stored point
   function automatic logic [33:0] dsq(input logic [47:0] p, input logic [47:0] q);
      logic signed [33:0] d;
      logic [33:0] s;
      s = '0;
      for (int k = 0; k < 3; k++) begin
         d = 34'(comp(p, 2'(k))) - 34'(comp(q, 2'(k)));
         s = s + 34'(d * d);
      end
      return s;
   endfunction

   logic hit_now;
   assign hit_now = (dsq(store_a[pt_sel], la_ff) < {2'd0, match_ff})
                 || (dsq(store_b[pt_sel], lb_ff) < {2'd0, match_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         la_ff <= req_local_a;
         lb_ff <= req_local_b;
         n_ff  <= req_contact_normal;
         ar_ff[0] <= req_a_row0; ar_ff[1] <= req_a_row1; ar_ff[2] <= req_a_row2;
         br_ff[0] <= req_b_row0; br_ff[1] <= req_b_row1; br_ff[2] <= req_b_row2;
         ap_ff <= req_a_position;
         bp_ff <= req_b_position;
         nok_ff <= nok_in;
         acc_ff <= '0;
      end
      if (cmd.check_pt) hit_ff <= hit_now;
      if (cmd.mul_world) begin
         for (int j = 0; j < 3; j++) begin
            pa_ff[j] <= comp(la_ff, 2'(j)) * comp(ar_ff[j], comp_sel);
            pb_ff[j] <= comp(lb_ff, 2'(j)) * comp(br_ff[j], comp_sel);
         end
         pa_ff[3] <= 32'(comp(ap_ff, comp_sel)) <<< 14;
         pb_ff[3] <= 32'(comp(bp_ff, comp_sel)) <<< 14;
      end
      if (cmd.acc_world)
         diff_ff <= (35'(pa_ff[0]) + 35'(pa_ff[1]) + 35'(pa_ff[2]) + 35'(pa_ff[3]))
                  - (35'(pb_ff[0]) + 35'(pb_ff[1]) + 35'(pb_ff[2]) + 35'(pb_ff[3]));
      if (cmd.mul_dot) prod_ff <= 51'(comp(n_ff, comp_sel)) * 51'(diff_ff);
      if (cmd.acc_dot) acc_ff <= acc_ff + 54'(prod_ff);
   end

   // round half away from zero to Q.22 and saturate
   logic [53:0] mag, rmag;
   logic signed [31:0] depth_val;
   always_comb begin
      mag  = acc_ff[53] ? 54'(-acc_ff) : 54'(acc_ff);
      rmag = (mag + 54'd8192) >> 14;
      if (acc_ff[53]) depth_val = (rmag >= 54'h80000000) ? 32'sh80000000 : -32'(rmag);
      else depth_val = (rmag > 54'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(rmag);
   end

   always_comb begin
      count_in = count_ff;
      if (commit_status == ST_CLEARED) count_in = '0;
      else if (commit_status == ST_APPENDED) count_in = count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.commit) count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status      <= commit_status;
         rsp_points_held <= 3'(count_in);
         case (commit_status)
            ST_APPENDED, ST_MATCHED: begin
               rsp_slot  <= 3'(hit_idx);
               rsp_depth <= depth_val;
               store_a[hit_idx] <= la_ff;
               store_b[hit_idx] <= lb_ff;
               store_n[hit_idx] <= n_ff;
               store_d[hit_idx] <= depth_val;
            end
            ST_CLEARED: begin
               rsp_slot  <= 3'd0;
               rsp_depth <= '0;
            end
            default: begin
               rsp_slot  <= 3'(count_ff);
               rsp_depth <= '0;
            end
         endcase
      end
   end

   assign count         = count_ff;
   assign sts.is_clear  = op_ff;
   assign sts.normal_ok = nok_ff;
   assign sts.hit       = hit_ff;
endmodule

>>> hdl/cmpi_control.sv
// Controller: sequences one item through matching, depth and commit.
`timescale 1ns / 1ps
module cmpi_control #(
   parameter int MAX_POINTS = cmpi_pkg::MAX_POINTS_DEFAULT,
   parameter int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   parameter int CNT_W = $clog2(MAX_POINTS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cmpi_pkg::cmd_type cmd,
   output logic [1:0]        comp_sel,
   output logic [IDX_W-1:0]  pt_sel,
   input  cmpi_pkg::sts_type sts,
   input  logic [CNT_W-1:0]  count,
   output logic [2:0]        commit_status,
   output logic [IDX_W-1:0]  hit_idx
);
   import cmpi_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MATCH = 3'd1;
   localparam logic [2:0] S_TEST  = 3'd2;
   localparam logic [2:0] S_DEPTH = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [2:0]       phase_ff, phase_in;
   logic [1:0]       k_ff, k_in;
   logic             rv_ff, rv_in;
   logic [2:0]       st_ff, st_in;

   assign req_ready = (state_ff == S_IDLE) && !(rv_ff && !rsp_ready);
   assign rsp_valid = rv_ff;
   assign comp_sel  = k_ff;
   assign pt_sel    = IDX_W'(idx_ff);
   assign hit_idx   = IDX_W'(idx_ff);
   assign commit_status = st_ff;

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; phase_in = phase_ff; k_in = k_ff;
      st_in = st_ff;
      rv_in = rv_ff && !rsp_ready;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               idx_in = '0;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            if (sts.is_clear) begin
               st_in = ST_CLEARED; state_in = S_DONE;
            end else if (!sts.normal_ok) begin
               st_in = ST_REJECTED; state_in = S_DONE;
            end else if (idx_ff < count) begin
               cmd.check_pt = 1'b1; state_in = S_TEST;
            end else if (count < CNT_W'(MAX_POINTS)) begin
               st_in = ST_APPENDED; idx_in = count;
               k_in = '0; phase_in = '0; state_in = S_DEPTH;
            end else begin
               st_in = ST_FULL; state_in = S_DONE;
            end
         end
         S_TEST: begin
            if (sts.hit) begin
               st_in = ST_MATCHED; k_in = '0; phase_in = '0; state_in = S_DEPTH;
            end else begin
               idx_in = idx_ff + 1'b1; state_in = S_MATCH;
            end
         end
         S_DEPTH: begin
            // per component: products, difference, times normal, accumulate
            phase_in = phase_ff + 3'd1;
            case (phase_ff)
               3'd0: cmd.mul_world = 1'b1;
               3'd1: cmd.acc_world = 1'b1;
               3'd2: cmd.mul_dot = 1'b1;
               default: begin
                  cmd.acc_dot = 1'b1;
                  phase_in = '0;
                  k_in = k_ff + 2'd1;
                  if (k_ff == 2'd2) state_in = S_DONE;
               end
            endcase
         end
         S_DONE: begin
            if (!rv_in) begin
               cmd.commit = 1'b1; rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0; idx_ff <= '0;
         phase_ff <= '0; k_ff <= '0; st_ff <= ST_APPENDED;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in; idx_ff <= idx_in;
         phase_ff <= phase_in; k_ff <= k_in; st_ff <= st_in;
      end
   end
endmodule

>>> hdl/contact_manifold_point_insert.sv
// Top level of the contact manifold point insert block.
`timescale 1ns / 1ps
// Keeps one contact manifold of up to MAX_POINTS points. Each request beat
// either clears the manifold or offers a contact point; one response beat
// follows every request beat. Clear and rejected-normal outcomes are
// decided before any stored point is compared; a full manifold first
// compares every stored point; a written point is compared with each
// stored point until one matches, then goes through the depth work, since
// a single set of multipliers forms the world products and the dot product
// one component at a time, in the steps products, difference, times normal
// and accumulate. The response register holds the result while the next
// request is accepted once the response has been taken. Configuration
// writes take effect at once and must be made while the block is idle.
module contact_manifold_point_insert #(
   parameter int MAX_POINTS = cmpi_pkg::MAX_POINTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [47:0] req_local_a,
   input  logic [47:0] req_local_b,
   input  logic [47:0] req_contact_normal,
   input  logic [47:0] req_a_row0,
   input  logic [47:0] req_a_row1,
   input  logic [47:0] req_a_row2,
   input  logic [47:0] req_a_position,
   input  logic [47:0] req_b_row0,
   input  logic [47:0] req_b_row1,
   input  logic [47:0] req_b_row2,
   input  logic [47:0] req_b_position,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_slot,
   output logic signed [31:0] rsp_depth,
   output logic [2:0]  rsp_points_held
);
   import cmpi_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   cmd_type          cmd;
   sts_type          sts;
   logic [1:0]       comp_sel;
   logic [IDX_W-1:0] pt_sel, hit_idx;
   logic [CNT_W-1:0] count;
   logic [2:0]       commit_status;

   cmpi_control #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .comp_sel, .pt_sel, .sts, .count, .commit_status, .hit_idx
   );

   cmpi_datapath #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_datapath (
      .clock, .reset, .cmd, .comp_sel, .pt_sel, .sts,
      .csr_we, .csr_index, .csr_wdata,
      .req_op, .req_local_a, .req_local_b, .req_contact_normal,
      .req_a_row0, .req_a_row1, .req_a_row2, .req_a_position,
      .req_b_row0, .req_b_row1, .req_b_row2, .req_b_position,
      .commit_status, .hit_idx, .count,
      .rsp_status, .rsp_slot, .rsp_depth, .rsp_points_held
   );
endmodule

>>> hdl/cmpi_checker.sv
// Port-level checker for the contact manifold point insert block, with its bind.
`timescale 1ns / 1ps
module cmpi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [2:0]  rsp_slot,
   input logic signed [31:0] rsp_depth,
   input logic [2:0]  rsp_points_held
);
   import cmpi_pkg::*;

   // A pending response holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response changed while stalled");

   // A cleared response reports an empty manifold.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_CLEARED |-> rsp_points_held == 3'd0
         && rsp_slot == 3'd0 && rsp_depth == 0)
      else $error("clear response not empty");

   // Outcomes that store nothing carry zero depth.
   a_nodepth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_REJECTED || rsp_status == ST_FULL)
         |-> rsp_depth == 0 && rsp_slot == rsp_points_held)
      else $error("unstored outcome carries depth");

   // An accepted request gives no response in the very next cycle.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("response too early");
endmodule

bind contact_manifold_point_insert cmpi_checker u_cmpi_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_slot, .rsp_depth, .rsp_points_held
);
